[src/lav_pkg.sv]
// ----------------------------------------------------------------------------
// lav_pkg
// Shared types for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lav_pkg;

  // one camera: eye, target and up hint, signed fixed point
  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] hint_up_x;
    logic signed [31:0] hint_up_y;
    logic signed [31:0] hint_up_z;
  } lav_in_t;

  // rotation rows and translation of the view matrix
  typedef struct packed {
    logic signed [31:0] right_x;
    logic signed [31:0] right_y;
    logic signed [31:0] right_z;
    logic signed [31:0] view_up_x;
    logic signed [31:0] view_up_y;
    logic signed [31:0] view_up_z;
    logic signed [31:0] forward_x;
    logic signed [31:0] forward_y;
    logic signed [31:0] forward_z;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
  } lav_out_t;

  // three 32-bit components, index 0 is x
  typedef logic [2:0][31:0] lav_vec32_t;

endpackage

`default_nettype wire

[src/look_at_view_matrix.sv]
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Left-handed look-at view matrix in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  input   | in_valid_i, in_stall_o, in_data_i    | camera in
//  output  | out_valid_o, out_stall_i, out_data_o | matrix out
//
//  One camera per cycle while out_stall_i is low. Most of the depth lies in
//  the two normalizers: square root one bit per stage over 31 stages,
//  division one quotient bit per stage over FRAC_BITS+1 stages.
//  Reset clears only the stage valid bits.
//  A stall squeezes out empty stages, so input is taken while any bubble
//  remains ahead of the stalled result.
// ----------------------------------------------------------------------------
`default_nettype none

module look_at_view_matrix
  import lav_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  lav_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output lav_out_t out_data_o
);

  localparam int unsigned OW  = FRAC_BITS + 2;
  localparam int unsigned SW1 = 96 + 96;
  localparam int unsigned SW2 = 96 + 3 * OW;
  localparam int unsigned SW3 = 96 + 6 * OW;

  // front stage: forward difference at 33 bits
  logic              f_vld_q;
  logic              f_en;
  logic [2:0][32:0]  diff_q;
  lav_vec32_t        eye_q;
  lav_vec32_t        up_q;
  lav_vec32_t        eye_d;
  lav_vec32_t        tgt_d;
  logic              nf_stall;

  assign eye_d      = {in_data_i.eye_z, in_data_i.eye_y, in_data_i.eye_x};
  assign tgt_d      = {in_data_i.target_z, in_data_i.target_y, in_data_i.target_x};
  assign f_en       = !f_vld_q || !nf_stall;
  assign in_stall_o = !f_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (f_en) begin
      f_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_en) begin
      for (int i = 0; i < 3; i++) begin
        diff_q[i] <= {tgt_d[i][31], tgt_d[i]} - {eye_d[i][31], eye_d[i]};
      end
      eye_q <= eye_d;
      up_q  <= {in_data_i.hint_up_z, in_data_i.hint_up_y, in_data_i.hint_up_x};
    end
  end

  // forward axis
  logic               nf_vld;
  logic               c1_stall;
  logic [2:0][OW-1:0] fwd;
  logic [SW1-1:0]     nf_side;

  lav_norm #(
    .IW        (33),
    .FRAC_BITS (FRAC_BITS),
    .SW        (SW1)
  ) u_norm_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_vld_q),
    .stall_o (nf_stall),
    .vec_i   (diff_q),
    .side_i  ({eye_q, up_q}),
    .valid_o (nf_vld),
    .stall_i (c1_stall),
    .vec_o   (fwd),
    .side_o  (nf_side)
  );

  // up hint cross forward
  logic                  c1_vld;
  logic                  nr_stall;
  logic [2:0][32+OW:0]   c1;
  logic [SW2-1:0]        c1_side;

  lav_cross #(
    .AW (32),
    .BW (OW),
    .SW (SW2)
  ) u_cross_rgt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (nf_vld),
    .stall_o (c1_stall),
    .a_i     (nf_side[95:0]),
    .b_i     (fwd),
    .side_i  ({nf_side[191:96], fwd}),
    .valid_o (c1_vld),
    .stall_i (nr_stall),
    .c_o     (c1),
    .side_o  (c1_side)
  );

  // right axis
  logic               nr_vld;
  logic               c2_stall;
  logic [2:0][OW-1:0] rgt;
  logic [SW2-1:0]     nr_side;

  lav_norm #(
    .IW        (33 + OW),
    .FRAC_BITS (FRAC_BITS),
    .SW        (SW2)
  ) u_norm_rgt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c1_vld),
    .stall_o (nr_stall),
    .vec_i   (c1),
    .side_i  (c1_side),
    .valid_o (nr_vld),
    .stall_i (c2_stall),
    .vec_o   (rgt),
    .side_o  (nr_side)
  );

  // forward cross right gives the true up axis
  logic                c2_vld;
  logic                dt_stall;
  logic [2:0][2*OW:0]  c2;
  logic [SW3-1:0]      c2_side;

  lav_cross #(
    .AW (OW),
    .BW (OW),
    .SW (SW3)
  ) u_cross_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (nr_vld),
    .stall_o (c2_stall),
    .a_i     (nr_side[3*OW-1:0]),
    .b_i     (rgt),
    .side_i  ({nr_side, rgt}),
    .valid_o (c2_vld),
    .stall_i (dt_stall),
    .c_o     (c2),
    .side_o  (c2_side)
  );

  // translations and output register
  lav_dot #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dot (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (c2_vld),
    .stall_o   (dt_stall),
    .up_wide_i (c2),
    .rgt_i     (c2_side[3*OW-1:0]),
    .fwd_i     (c2_side[6*OW-1:3*OW]),
    .eye_i     (c2_side[SW3-1:6*OW]),
    .valid_o   (out_valid_o),
    .stall_i   (out_stall_i),
    .out_o     (out_data_o)
  );

`ifndef NO_ASSERTIONS
  localparam logic signed [31:0] FwdMax = 32'sd1 <<< FRAC_BITS;

  // a moving output never holds back the input side
  a_drain_open : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output side is free");

  // x and z of the unit forward axis never exceed one in magnitude
  a_fwd_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.forward_x <= FwdMax) && (out_data_o.forward_x >= -FwdMax)
                 && (out_data_o.forward_z <= FwdMax) && (out_data_o.forward_z >= -FwdMax))
    else $error("forward axis out of range");

  // a zero forward axis forces a zero right axis and a zero up y
  a_zero_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.forward_x == 0) && (out_data_o.forward_y == 0)
      && (out_data_o.forward_z == 0)
      |-> (out_data_o.right_x == 0) && (out_data_o.right_y == 0)
       && (out_data_o.right_z == 0) && (out_data_o.view_up_y == 0))
    else $error("nonzero axes from zero forward axis");
`endif

endmodule

`default_nettype wire

[src/lav_norm.sv]
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalizer: power-of-two prescale, sum of squares,
// bit-per-stage integer square root, bit-per-stage division by the length.
// ----------------------------------------------------------------------------
`default_nettype none

module lav_norm
  import lav_pkg::*;
#(
  parameter int unsigned IW        = 33,
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned SW        = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic [2:0][IW-1:0]           vec_i,
  input  logic [SW-1:0]                side_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic [2:0][FRAC_BITS+1:0]    vec_o,
  output logic [SW-1:0]                side_o
);

  localparam int unsigned WW    = (IW > 30) ? IW : 30;
  localparam int unsigned NSH   = 6;
  localparam int unsigned NRT   = 31;
  localparam int unsigned NDV   = FRAC_BITS + 1;
  localparam int unsigned OW    = FRAC_BITS + 2;
  localparam int unsigned DW    = FRAC_BITS + 32;
  localparam int unsigned S_SQ  = NSH + 1;
  localparam int unsigned S_SUM = S_SQ + 1;
  localparam int unsigned S_RT  = S_SUM + 1;
  localparam int unsigned S_PRE = S_RT + NRT;
  localparam int unsigned S_DV  = S_PRE + 1;
  localparam int unsigned NS    = S_DV + NDV;

  // stage valid bits, a stage loads when empty or when everything after moves
  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = !stall_i || !(&vld_q[NS-1:k]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (en & {vld_q[NS-2:0], valid_i}) | (~en & vld_q);
    end
  end

  assign stall_o = !en[0];
  assign valid_o = vld_q[NS-1];

  // stage 0: magnitudes, signs and largest magnitude
  logic [2:0][WW-1:0] mag_d;
  logic [WW-1:0]      top_d;
  logic [2:0]         neg_d;

  always_comb begin
    logic [IW-1:0] m_t;
    top_d = '0;
    for (int i = 0; i < 3; i++) begin
      neg_d[i] = vec_i[i][IW-1];
      m_t      = vec_i[i][IW-1] ? (~vec_i[i] + 1'b1) : vec_i[i];
      mag_d[i] = WW'(m_t);
      if (mag_d[i] > top_d) begin
        top_d = mag_d[i];
      end
    end
  end

  // sign, zero flag and side data ride along every stage
  logic [2:0]    neg_q  [NS];
  logic          zero_q [NS];
  logic [SW-1:0] side_q [NS];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      neg_q[0]  <= neg_d;
      zero_q[0] <= (top_d == '0);
      side_q[0] <= side_i;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        neg_q[k]  <= neg_q[k-1];
        zero_q[k] <= zero_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // prescale stages bring the largest magnitude into [2^29, 2^30)
  logic [2:0][WW-1:0] a_q   [0:NSH];
  logic [WW-1:0]      top_q [0:NSH];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_q[0]   <= mag_d;
      top_q[0] <= top_d;
    end
  end

  for (genvar j = 0; j < NSH; j++) begin : g_sh
    localparam int unsigned SH = 32 >> j;
    localparam int unsigned LS = (SH <= 16) ? (30 - SH) : 0;
    logic               rsh;
    logic               lsh;
    logic [2:0][WW-1:0] a_d;
    logic [WW-1:0]      t_d;

    always_comb begin
      rsh = 64'(top_q[j]) >= (64'd1 << (29 + SH));
      lsh = (SH <= 16) && (64'(top_q[j]) < (64'd1 << LS));
      for (int i = 0; i < 3; i++) begin
        if (rsh) begin
          a_d[i] = a_q[j][i] >> SH;
        end else if (lsh) begin
          a_d[i] = a_q[j][i] << SH;
        end else begin
          a_d[i] = a_q[j][i];
        end
      end
      if (rsh) begin
        t_d = top_q[j] >> SH;
      end else if (lsh) begin
        t_d = top_q[j] << SH;
      end else begin
        t_d = top_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[j+1]) begin
        a_q[j+1]   <= a_d;
        top_q[j+1] <= t_d;
      end
    end
  end

  // squares, then their sum
  logic [2:0][59:0] sq_q;
  logic [2:0][29:0] av_q  [S_SQ:S_PRE-1];
  logic [61:0]      rem_q [S_SUM:S_PRE-1];
  logic [62:0]      res_q [S_SUM:S_PRE-1];

  always_ff @(posedge clk_i) begin
    if (en[S_SQ]) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i]       <= a_q[NSH][i][29:0] * a_q[NSH][i][29:0];
        av_q[S_SQ][i] <= a_q[NSH][i][29:0];
      end
    end
    if (en[S_SUM]) begin
      rem_q[S_SUM] <= 62'(sq_q[0]) + 62'(sq_q[1]) + 62'(sq_q[2]);
      res_q[S_SUM] <= '0;
      av_q[S_SUM]  <= av_q[S_SQ];
    end
  end

  // square root, one result bit per stage
  for (genvar i = 0; i < NRT; i++) begin : g_rt
    localparam int unsigned K  = S_RT + i;
    localparam int unsigned BP = 2 * (NRT - 1 - i);
    logic [62:0] trial;
    logic [61:0] rem_d;
    logic [62:0] res_d;

    always_comb begin
      trial = res_q[K-1] + (63'd1 << BP);
      if ({1'b0, rem_q[K-1]} >= trial) begin
        rem_d = rem_q[K-1] - trial[61:0];
        res_d = (res_q[K-1] >> 1) + (63'd1 << BP);
      end else begin
        rem_d = rem_q[K-1];
        res_d = res_q[K-1] >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[K]) begin
        rem_q[K] <= rem_d;
        res_q[K] <= res_d;
        av_q[K]  <= av_q[K-1];
      end
    end
  end

  // dividend with half the length added for rounding
  logic [2:0][DW-1:0]        dr_q  [S_PRE:NS-2];
  logic [31:0]               len_q [S_PRE:NS-2];
  logic [2:0][FRAC_BITS:0]   q_q   [S_PRE:NS-1];

  always_ff @(posedge clk_i) begin
    if (en[S_PRE]) begin
      len_q[S_PRE] <= res_q[S_PRE-1][31:0];
      q_q[S_PRE]   <= '0;
      for (int i = 0; i < 3; i++) begin
        dr_q[S_PRE][i] <= (DW'(av_q[S_PRE-1][i]) << FRAC_BITS)
                        + DW'(res_q[S_PRE-1][31:1]);
      end
    end
  end

  // division, one quotient bit per stage
  for (genvar i = 0; i < NDV; i++) begin : g_dv
    localparam int unsigned K = S_DV + i;
    localparam int unsigned B = FRAC_BITS - i;
    logic [2:0][DW-1:0]      dr_d;
    logic [2:0][FRAC_BITS:0] q_d;
    logic [DW-1:0]           dv;

    always_comb begin
      dv  = DW'(len_q[K-1]) << B;
      q_d = q_q[K-1];
      for (int c = 0; c < 3; c++) begin
        if (dr_q[K-1][c] >= dv) begin
          dr_d[c]   = dr_q[K-1][c] - dv;
          q_d[c][B] = 1'b1;
        end else begin
          dr_d[c] = dr_q[K-1][c];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[K]) begin
        q_q[K] <= q_d;
      end
    end

    if (K < NS - 1) begin : g_pass
      always_ff @(posedge clk_i) begin
        if (en[K]) begin
          dr_q[K]  <= dr_d;
          len_q[K] <= len_q[K-1];
        end
      end
    end
  end

  // sign back on, zero-length vectors stay zero
  always_comb begin
    logic [OW-1:0] m_t;
    for (int i = 0; i < 3; i++) begin
      m_t = OW'(q_q[NS-1][i]);
      if (zero_q[NS-1]) begin
        vec_o[i] = '0;
      end else if (neg_q[NS-1][i]) begin
        vec_o[i] = ~m_t + 1'b1;
      end else begin
        vec_o[i] = m_t;
      end
    end
  end

  assign side_o = side_q[NS-1];

endmodule

`default_nettype wire

[src/lav_cross.sv]
// ----------------------------------------------------------------------------
// lav_cross
// Two-stage cross product: six products, then the three differences.
// ----------------------------------------------------------------------------
`default_nettype none

module lav_cross
  import lav_pkg::*;
#(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 18,
  parameter int unsigned SW = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    stall_o,
  input  logic [2:0][AW-1:0]      a_i,
  input  logic [2:0][BW-1:0]      b_i,
  input  logic [SW-1:0]           side_i,
  output logic                    valid_o,
  input  logic                    stall_i,
  output logic [2:0][AW+BW:0]     c_o,
  output logic [SW-1:0]           side_o
);

  localparam int unsigned PW = AW + BW;

  logic [1:0] vld_q;
  logic [1:0] en;

  assign en[1]   = !stall_i || !vld_q[1];
  assign en[0]   = !stall_i || !(&vld_q);
  assign stall_o = !en[0];
  assign valid_o = vld_q[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (en & {vld_q[0], valid_i}) | (~en & vld_q);
    end
  end

  // products
  logic signed [PW-1:0] prod_d [6];
  logic signed [PW-1:0] prod_q [6];
  logic [SW-1:0]        side_q [2];

  always_comb begin
    prod_d[0] = $signed(a_i[1]) * $signed(b_i[2]);
    prod_d[1] = $signed(a_i[2]) * $signed(b_i[1]);
    prod_d[2] = $signed(a_i[2]) * $signed(b_i[0]);
    prod_d[3] = $signed(a_i[0]) * $signed(b_i[2]);
    prod_d[4] = $signed(a_i[0]) * $signed(b_i[1]);
    prod_d[5] = $signed(a_i[1]) * $signed(b_i[0]);
  end

  // differences
  logic [2:0][PW:0] c_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      prod_q    <= prod_d;
      side_q[0] <= side_i;
    end
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        c_q[i] <= {prod_q[2*i][PW-1], prod_q[2*i]}
                - {prod_q[2*i+1][PW-1], prod_q[2*i+1]};
      end
      side_q[1] <= side_q[0];
    end
  end

  assign c_o    = c_q;
  assign side_o = side_q[1];

endmodule

`default_nettype wire

[src/lav_dot.sv]
// ----------------------------------------------------------------------------
// lav_dot
// Rounds the up axis, forms the three translations as minus axis dot eye,
// rounds and saturates, and holds the finished matrix in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lav_dot
  import lav_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           stall_o,
  input  logic [2:0][2*FRAC_BITS+4:0]    up_wide_i,
  input  logic [2:0][FRAC_BITS+1:0]      rgt_i,
  input  logic [2:0][FRAC_BITS+1:0]      fwd_i,
  input  lav_vec32_t                     eye_i,
  output logic                           valid_o,
  input  logic                           stall_i,
  output lav_out_t                       out_o
);

  localparam int unsigned OW  = FRAC_BITS + 2;
  localparam int unsigned CW  = 2 * OW + 1;
  localparam int unsigned AXW = FRAC_BITS + 3;
  localparam int unsigned PW  = AXW + 32;
  localparam int unsigned PS  = PW + 2;
  localparam int unsigned NS  = 4;

  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = !stall_i || !(&vld_q[NS-1:k]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (en & {vld_q[NS-2:0], valid_i}) | (~en & vld_q);
    end
  end

  assign stall_o = !en[0];
  assign valid_o = vld_q[NS-1];

  // stage 0: up axis rounded to nearest, ties away from zero
  logic [2:0][AXW-1:0] tup_d;

  always_comb begin
    logic [CW-1:0] m_t;
    logic [CW-1:0] r_t;
    for (int i = 0; i < 3; i++) begin
      m_t = up_wide_i[i][CW-1] ? (~up_wide_i[i] + 1'b1) : up_wide_i[i];
      r_t = (m_t + (CW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (up_wide_i[i][CW-1]) begin
        r_t = ~r_t + 1'b1;
      end
      tup_d[i] = r_t[AXW-1:0];
    end
  end

  // axes: 0 right, 1 up, 2 forward
  logic [2:0][2:0][AXW-1:0] ax_q [3];
  lav_vec32_t               eye_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        ax_q[0][0][i] <= AXW'($signed(rgt_i[i]));
        ax_q[0][2][i] <= AXW'($signed(fwd_i[i]));
      end
      ax_q[0][1] <= tup_d;
      eye_q      <= eye_i;
    end
    for (int k = 1; k < 3; k++) begin
      if (en[k]) begin
        ax_q[k] <= ax_q[k-1];
      end
    end
  end

  // stage 1: nine products
  logic signed [PW-1:0] prod_q [3][3];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int a = 0; a < 3; a++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[a][c] <= $signed(ax_q[0][a][c]) * $signed(eye_q[c]);
        end
      end
    end
  end

  // stage 2: dot sums
  logic signed [PS-1:0] sum_q [3];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int a = 0; a < 3; a++) begin
        sum_q[a] <= PS'(prod_q[a][0]) + PS'(prod_q[a][1]) + PS'(prod_q[a][2]);
      end
    end
  end

  // stage 3: negate, round, saturate, pack the result
  logic [2:0][31:0] shf_d;

  always_comb begin
    logic [PS-1:0] m_t;
    logic [PS-1:0] r_t;
    logic          pos;
    for (int a = 0; a < 3; a++) begin
      pos = !sum_q[a][PS-1] && (sum_q[a] != '0);
      m_t = sum_q[a][PS-1] ? (~sum_q[a] + 1'b1) : sum_q[a];
      r_t = (m_t + (PS'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (pos) begin
        if (r_t > PS'(33'h080000000)) begin
          shf_d[a] = 32'h80000000;
        end else begin
          shf_d[a] = ~r_t[31:0] + 1'b1;
        end
      end else begin
        if (r_t > PS'(33'h07fffffff)) begin
          shf_d[a] = 32'h7fffffff;
        end else begin
          shf_d[a] = r_t[31:0];
        end
      end
    end
  end

  lav_out_t out_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      out_q.right_x   <= 32'($signed(ax_q[2][0][0]));
      out_q.right_y   <= 32'($signed(ax_q[2][0][1]));
      out_q.right_z   <= 32'($signed(ax_q[2][0][2]));
      out_q.view_up_x <= 32'($signed(ax_q[2][1][0]));
      out_q.view_up_y <= 32'($signed(ax_q[2][1][1]));
      out_q.view_up_z <= 32'($signed(ax_q[2][1][2]));
      out_q.forward_x <= 32'($signed(ax_q[2][2][0]));
      out_q.forward_y <= 32'($signed(ax_q[2][2][1]));
      out_q.forward_z <= 32'($signed(ax_q[2][2][2]));
      out_q.shift_x   <= shf_d[0];
      out_q.shift_y   <= shf_d[1];
      out_q.shift_z   <= shf_d[2];
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire
